// File: rtl/core/lsbsc_pkg.sv
`default_nettype none

package lsbsc_pkg;

    // defaults for the top-level parameters
    localparam int SECRET_DEPTH_DEF  = 256;
    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W         = 8;
    localparam int BIT_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int INTERVAL_SHIFT = 11;
    localparam int INTERVAL_W     = CFG_DATA_W - INTERVAL_SHIFT;
    localparam int FIRST_TARGET   = 100;

    // register indexes
    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    // mode register values
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_CARRIER = 2'd1,
        ACT_START   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        PH_DATA = 3'b001,
        PH_TERM = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] carrier_out;
        logic              recovered_valid;
        logic [BYTE_W-1:0] recovered_byte;
        logic              message_done;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/lsbsc_secret_mem.sv
`default_nettype none

module lsbsc_secret_mem #(
    parameter int SECRET_DEPTH = lsbsc_pkg::SECRET_DEPTH_DEF,
    parameter int ADDR_W       = $clog2(SECRET_DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [ADDR_W-1:0]             waddr,
    input  wire logic [lsbsc_pkg::BYTE_W-1:0]  wdata,
    input  wire logic [ADDR_W-1:0]             raddr,
    output logic      [lsbsc_pkg::BYTE_W-1:0]  rdata
);

    logic [lsbsc_pkg::BYTE_W-1:0] mem [SECRET_DEPTH];
    logic [lsbsc_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-through so a same-cycle write to the read address is seen
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/lsbsc_ctrl.sv
`default_nettype none

module lsbsc_ctrl #(
    parameter int SECRET_DEPTH  = lsbsc_pkg::SECRET_DEPTH_DEF,
    parameter int POSITION_BITS = lsbsc_pkg::POSITION_BITS_DEF,
    parameter int ADDR_W        = $clog2(SECRET_DEPTH)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic                              cfg_index,
    input  wire logic [lsbsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              accept,
    input  wire logic [1:0]                        action,
    input  wire logic [lsbsc_pkg::BYTE_W-1:0]      value_byte,
    input  wire logic [lsbsc_pkg::BYTE_W-1:0]      rd_data,
    output logic                                   mem_we,
    output logic      [ADDR_W-1:0]                 mem_waddr,
    output logic      [lsbsc_pkg::BYTE_W-1:0]      mem_wdata,
    output logic      [ADDR_W-1:0]                 mem_raddr,
    output logic                                   res_valid,
    output lsbsc_pkg::result_t                     res
);

    localparam int RP_W = ADDR_W + 1;
    localparam int BW   = lsbsc_pkg::BYTE_W;
    localparam int BIW  = lsbsc_pkg::BIT_IDX_W;
    localparam int IVW  = lsbsc_pkg::INTERVAL_W;

    logic                                 mode_reg;
    logic [lsbsc_pkg::CFG_DATA_W-1:0]     length_reg;

    logic [ADDR_W-1:0]        slen_reg, slen_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [BIW-1:0]           bc_reg, bc_next;
    logic [RP_W-1:0]          rp_reg, rp_next;
    lsbsc_pkg::phase_t        phase_reg, phase_next;
    logic [BW-1:0]            asm_reg, asm_next;

    logic [IVW-1:0]  interval;
    logic            touch;
    logic            emb_bit;
    logic [RP_W-1:0] rp_inc;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lsbsc_pkg::MODE_EMBED;
            length_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                lsbsc_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                lsbsc_pkg::CFG_LENGTH: length_reg <= cfg_data;
                default:               mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        interval = length_reg[lsbsc_pkg::CFG_DATA_W-1:lsbsc_pkg::INTERVAL_SHIFT];
        if (interval == '0)
        begin
            interval = IVW'(1);
        end
    end

    assign rp_inc = rp_reg + RP_W'(1);

    always_comb
    begin
        slen_next   = slen_reg;
        pos_next    = pos_reg;
        target_next = target_reg;
        bc_next     = bc_reg;
        rp_next     = rp_reg;
        phase_next  = phase_reg;
        asm_next    = asm_reg;
        mem_we      = 1'b0;
        mem_waddr   = slen_reg;
        mem_wdata   = value_byte;
        res_valid   = 1'b0;
        touch       = 1'b0;
        emb_bit     = 1'b0;
        res.carrier_out     = value_byte;
        res.recovered_valid = 1'b0;
        res.recovered_byte  = '0;

        if (accept)
        begin
            unique case (action)
                lsbsc_pkg::ACT_LOAD:
                begin
                    if (slen_reg != ADDR_W'(SECRET_DEPTH - 1))
                    begin
                        mem_we    = 1'b1;
                        slen_next = slen_reg + ADDR_W'(1);
                    end
                end
                lsbsc_pkg::ACT_START:
                begin
                    slen_next   = '0;
                    pos_next    = '0;
                    target_next = POSITION_BITS'(lsbsc_pkg::FIRST_TARGET);
                    bc_next     = '0;
                    rp_next     = '0;
                    phase_next  = lsbsc_pkg::PH_DATA;
                    asm_next    = '0;
                end
                lsbsc_pkg::ACT_CARRIER:
                begin
                    res_valid = 1'b1;
                    touch     = (phase_reg != lsbsc_pkg::PH_DONE) && (pos_reg == target_reg);
                    pos_next  = pos_reg + POSITION_BITS'(1);
                    if (touch)
                    begin
                        target_next = target_reg + POSITION_BITS'(interval);
                        bc_next     = bc_reg + BIW'(1);
                        if (mode_reg == lsbsc_pkg::MODE_EMBED)
                        begin
                            // secret exhausted: terminator starts at bit 0
                            if (phase_reg == lsbsc_pkg::PH_DATA
                                && rp_reg >= RP_W'(slen_reg))
                            begin
                                phase_next = lsbsc_pkg::PH_TERM;
                                bc_next    = BIW'(1);
                            end
                            else if (phase_reg == lsbsc_pkg::PH_DATA)
                            begin
                                emb_bit = rd_data[bc_reg];
                                if (bc_reg == BIW'(BW - 1))
                                begin
                                    rp_next = rp_inc;
                                    if (rp_inc >= RP_W'(slen_reg))
                                    begin
                                        phase_next = lsbsc_pkg::PH_TERM;
                                    end
                                end
                            end
                            else if (bc_reg == BIW'(BW - 1))
                            begin
                                phase_next = lsbsc_pkg::PH_DONE;
                            end
                            res.carrier_out = {value_byte[BW-1:1], emb_bit};
                        end
                        else
                        begin
                            asm_next         = asm_reg;
                            asm_next[bc_reg] = asm_reg[bc_reg] | value_byte[0];
                            if (bc_reg == BIW'(BW - 1))
                            begin
                                res.recovered_valid = 1'b1;
                                res.recovered_byte  = asm_next;
                                rp_next             = rp_inc;
                                if (asm_next == '0 || rp_inc >= RP_W'(SECRET_DEPTH))
                                begin
                                    phase_next = lsbsc_pkg::PH_DONE;
                                end
                                asm_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end

        res.message_done = (phase_next == lsbsc_pkg::PH_DONE);
        mem_raddr        = rp_next[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slen_reg   <= '0;
            pos_reg    <= '0;
            target_reg <= POSITION_BITS'(lsbsc_pkg::FIRST_TARGET);
            bc_reg     <= '0;
            rp_reg     <= '0;
            phase_reg  <= lsbsc_pkg::PH_DATA;
            asm_reg    <= '0;
        end
        else
        begin
            slen_reg   <= slen_next;
            pos_reg    <= pos_next;
            target_reg <= target_next;
            bc_reg     <= bc_next;
            rp_reg     <= rp_next;
            phase_reg  <= phase_next;
            asm_reg    <= asm_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lsbsc_out_buf.sv
`default_nettype none

module lsbsc_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lsbsc_pkg::result_t push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output lsbsc_pkg::result_t      out_data
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    lsbsc_pkg::result_t out_data_reg, out_data_next;
    lsbsc_pkg::result_t skid_data_reg, skid_data_next;
    logic               out_fire;

    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (push)
        begin
            // skid is empty whenever a word is pushed
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/lsb_interval_stego_codec.sv
// lsb interval steganography codec, embed and extract
// results are registered in the output buffer; throughput: one word per
//   cycle while in_stall is low; the secret byte feeding the embed bit comes
//   from a one-port-write, registered-read memory that is re-read every cycle
// reset: rst_n clears counters, phase and config at once; the secret store
//   is not cleared and needs no sweep, so words are taken right after reset
`default_nettype none

module lsb_interval_stego_codec #(
    parameter int SECRET_DEPTH  = lsbsc_pkg::SECRET_DEPTH_DEF,
    parameter int POSITION_BITS = lsbsc_pkg::POSITION_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_write_en,
    input  wire logic                              cfg_index,
    input  wire logic [lsbsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input words
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        action,
    input  wire logic [lsbsc_pkg::BYTE_W-1:0]      value_byte,
    // result words, one per carrier byte
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [lsbsc_pkg::BYTE_W-1:0]      carrier_out,
    output logic                                   recovered_valid,
    output logic      [lsbsc_pkg::BYTE_W-1:0]      recovered_byte,
    output logic                                   message_done
);

    localparam int ADDR_W = $clog2(SECRET_DEPTH);

    logic                          accept;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [lsbsc_pkg::BYTE_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [lsbsc_pkg::BYTE_W-1:0]  mem_rdata;
    logic                          res_valid;
    lsbsc_pkg::result_t            res;
    lsbsc_pkg::result_t            out_data;
    logic                          buf_full;

    // a word is taken whenever the skid slot is free, even while the
    // output register holds a word the consumer is stalling on
    assign in_stall = buf_full;
    assign accept   = in_valid && !in_stall;

    // the controller reads the store at the read position it moves to, so the
    // registered data lines up with the next carrier word; loads write at the
    // fill count and are forwarded into the read register on an address match
    lsbsc_ctrl #(
        .SECRET_DEPTH  (SECRET_DEPTH),
        .POSITION_BITS (POSITION_BITS),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .action       (action),
        .value_byte   (value_byte),
        .rd_data      (mem_rdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .res_valid    (res_valid),
        .res          (res)
    );

    // secret byte store
    lsbsc_secret_mem #(
        .SECRET_DEPTH (SECRET_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_secret_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register plus skid slot
    lsbsc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign carrier_out     = out_data.carrier_out;
    assign recovered_valid = out_data.recovered_valid;
    assign recovered_byte  = out_data.recovered_byte;
    assign message_done    = out_data.message_done;

`ifndef NO_ASSERTIONS
    // skid slot only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid slot full with empty output register");

    // a recovered zero byte always ends the message
    a_zero_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && recovered_valid && recovered_byte == '0) |-> message_done)
        else $error("zero byte recovered without message done");

    // a store write never lands while a carrier word is being processed
    a_no_load_on_carrier: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !mem_we)
        else $error("store write on a carrier word");
`endif

endmodule

`default_nettype wire
